// ===== sv/sme_pkg.sv =====
// shared types and constants for the seniority master election block
// no dependencies; every other file except sme_ram refers to this package by scoped names
package sme_pkg;

  localparam int ID_W       = 8;
  localparam int SEC_W      = 32;
  localparam int NSEC_W     = 30;
  localparam int LIM_W      = 8;
  localparam int CNT_W      = 5;
  localparam int PSTATE_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_INIT_SEC  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_INIT_NSEC = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PENDING_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_LIMIT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NET_ATTACHED   = 3'd5;

  localparam logic MODE_PENDING = 1'b0;
  localparam logic MODE_READY   = 1'b1;

  localparam logic ACT_TICK     = 1'b0;
  localparam logic ACT_ANNOUNCE = 1'b1;

  localparam logic [PSTATE_W-1:0] PEER_READY = 2'd1;

  localparam logic [LIM_W-1:0] TICK_MAX = '1;

  typedef struct packed {
    logic                action;
    logic [ID_W-1:0]     peer_id;
    logic [PSTATE_W-1:0] peer_state;
    logic [ID_W-1:0]     peer_master_id;
    logic                peer_has_master;
    logic [SEC_W-1:0]    peer_init_sec;
    logic [NSEC_W-1:0]   peer_init_nsec;
  } in_item_t;

  typedef struct packed {
    logic             self_state;
    logic [ID_W-1:0]  master_id;
    logic             has_master;
    logic             is_master;
    logic [CNT_W-1:0] neighbour_count;
    logic             announce;
    logic             replay_request;
    logic             table_full;
  } out_item_t;

  // one neighbour table row
  typedef struct packed {
    logic [ID_W-1:0]         peer;
    logic [ID_W:0]           master;
    logic [PSTATE_W-1:0]     mode;
    logic [SEC_W+NSEC_W-1:0] start_time;
  } entry_t;

  typedef struct packed {
    logic [ID_W-1:0]   self_id;
    logic [SEC_W-1:0]  init_sec;
    logic [NSEC_W-1:0] init_nsec;
    logic [LIM_W-1:0]  pend_limit;
    logic [LIM_W-1:0]  sync_limit;
  } elect_cfg_t;

  typedef struct packed {
    logic apply;
    logic attached;
    logic detach;
  } elect_cmd_t;

  typedef struct packed {
    logic            mode;
    logic [ID_W-1:0] master;
    logic            known;
    logic            announce;
    logic            replay;
  } elect_stat_t;

  typedef struct packed {
    logic done;
    logic full;
  } tbl_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TABLE,
    ST_RESULT
  } top_state_t;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_SCAN,
    TS_DRAIN,
    TS_WRITE
  } tbl_state_t;

endpackage

// ===== sv/sme_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module sme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/sme_elect.sv =====
// election state: node mode, followed master, tick counters, replay tracking
// depends on sme_pkg
module sme_elect #(
  parameter int MAX_NODES = 16,
  localparam int CW = $clog2(MAX_NODES + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sme_pkg::elect_cfg_t   cfg,
  input  sme_pkg::elect_cmd_t   cmd,
  input  sme_pkg::in_item_t     item,
  input  logic [CW-1:0]         nb_count,
  output sme_pkg::elect_stat_t  stat
);

  logic                     mode_r, mode_nxt;
  logic [sme_pkg::ID_W-1:0] master_r, master_nxt;
  logic                     known_r, known_nxt;
  logic [sme_pkg::LIM_W-1:0] pend_r, pend_nxt;
  logic [sme_pkg::LIM_W-1:0] sync_r, sync_nxt;
  logic                     was_r, was_nxt;
  logic [CW-1:0]            last_r, last_nxt;
  logic                     ann_r, ann_nxt;
  logic                     rep_r, rep_nxt;

  logic [sme_pkg::LIM_W-1:0] pend_inc, sync_inc;
  logic                      older, self_m, self_m_nxt, peer_ready;

  assign pend_inc   = (pend_r == sme_pkg::TICK_MAX) ? pend_r : pend_r + 1'b1;
  assign sync_inc   = (sync_r == sme_pkg::TICK_MAX) ? sync_r : sync_r + 1'b1;
  assign self_m     = known_r && (master_r == cfg.self_id);
  assign peer_ready = (item.peer_state == sme_pkg::PEER_READY);
  // seconds first, nanoseconds break the tie; equal is not older
  assign older = (item.peer_init_sec < cfg.init_sec) ||
                 ((item.peer_init_sec == cfg.init_sec) &&
                  (item.peer_init_nsec < cfg.init_nsec));

  always_comb begin
    mode_nxt   = mode_r;
    master_nxt = master_r;
    known_nxt  = known_r;
    pend_nxt   = pend_r;
    sync_nxt   = sync_r;
    was_nxt    = was_r;
    last_nxt   = last_r;
    ann_nxt    = ann_r;
    rep_nxt    = rep_r;
    self_m_nxt = 1'b0;
    if (cmd.detach) begin
      mode_nxt   = sme_pkg::MODE_READY;
      master_nxt = cfg.self_id;
      known_nxt  = 1'b1;
      pend_nxt   = '0;
      sync_nxt   = '0;
    end else if (cmd.apply) begin
      ann_nxt = 1'b0;
      rep_nxt = 1'b0;
      if (cmd.attached && item.action == sme_pkg::ACT_TICK) begin
        if (mode_r == sme_pkg::MODE_PENDING) begin
          pend_nxt = pend_inc;
          if (pend_inc >= cfg.pend_limit) begin
            mode_nxt   = sme_pkg::MODE_READY;
            master_nxt = cfg.self_id;
            known_nxt  = 1'b1;
            pend_nxt   = '0;
            sync_nxt   = '0;
          end
        end else if (!self_m) begin
          sync_nxt = sync_inc;
          if (sync_inc >= cfg.sync_limit) begin
            mode_nxt   = sme_pkg::MODE_PENDING;
            master_nxt = '0;
            known_nxt  = 1'b0;
            pend_nxt   = '0;
            sync_nxt   = '0;
          end
        end
        ann_nxt    = 1'b1;
        self_m_nxt = known_nxt && (master_nxt == cfg.self_id);
        rep_nxt    = self_m_nxt && (!was_r || (last_r != nb_count));
        last_nxt   = nb_count;
        was_nxt    = self_m_nxt;
      end else if (cmd.attached) begin
        if (mode_r == sme_pkg::MODE_PENDING) begin
          if (peer_ready && item.peer_has_master) begin
            mode_nxt   = sme_pkg::MODE_READY;
            master_nxt = item.peer_master_id;
            known_nxt  = 1'b1;
            pend_nxt   = '0;
            sync_nxt   = '0;
            ann_nxt    = 1'b1;
          end
        end else if (known_r && item.peer_id == master_r) begin
          // our master speaks: either a heartbeat or it steps down
          if (peer_ready) begin
            sync_nxt = '0;
          end else begin
            mode_nxt   = sme_pkg::MODE_PENDING;
            master_nxt = '0;
            known_nxt  = 1'b0;
            pend_nxt   = '0;
            sync_nxt   = '0;
            ann_nxt    = 1'b1;
          end
        end else if (peer_ready && item.peer_has_master &&
                     (!known_r || item.peer_master_id != master_r) && older) begin
          mode_nxt   = sme_pkg::MODE_READY;
          master_nxt = item.peer_master_id;
          known_nxt  = 1'b1;
          pend_nxt   = '0;
          sync_nxt   = '0;
          ann_nxt    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= sme_pkg::MODE_PENDING;
      master_r <= '0;
      known_r  <= 1'b0;
      pend_r   <= '0;
      sync_r   <= '0;
      was_r    <= 1'b0;
      last_r   <= '0;
      ann_r    <= 1'b0;
      rep_r    <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      master_r <= master_nxt;
      known_r  <= known_nxt;
      pend_r   <= pend_nxt;
      sync_r   <= sync_nxt;
      was_r    <= was_nxt;
      last_r   <= last_nxt;
      ann_r    <= ann_nxt;
      rep_r    <= rep_nxt;
    end
  end

  assign stat.mode     = mode_r;
  assign stat.master   = master_r;
  assign stat.known    = known_r;
  assign stat.announce = ann_r;
  assign stat.replay   = rep_r;

endmodule

// ===== sv/sme_table.sv =====
// neighbour table: valid bits in flops, rows in a ram, sequential lookup then update
// depends on sme_pkg and sme_ram
module sme_table #(
  parameter int MAX_NODES = 16,
  localparam int AW = $clog2(MAX_NODES),
  localparam int CW = $clog2(MAX_NODES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req,
  input  sme_pkg::in_item_t   item,
  output sme_pkg::tbl_stat_t  stat,
  output logic [CW-1:0]       count
);

  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_NODES - 1);

  sme_pkg::tbl_state_t state_r, state_nxt;

  sme_pkg::in_item_t   item_r;
  logic [AW-1:0]       addr_r;
  logic                chk_on_r;
  logic [AW-1:0]       chk_idx_r;
  logic                found_r;
  logic [AW-1:0]       found_idx_r;
  logic                free_r;
  logic [AW-1:0]       free_idx_r;
  logic                full_r;
  logic [MAX_NODES-1:0] valid_r;
  logic [CW-1:0]       count_r;

  sme_pkg::entry_t     rd_entry, wr_entry;
  logic                ram_we;
  logic [AW-1:0]       slot;
  logic                gone, can_store, hit, free_here, writing;

  sme_ram #(
    .WIDTH ($bits(sme_pkg::entry_t)),
    .DEPTH (MAX_NODES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (wr_entry),
    .raddr (addr_r),
    .rdata (rd_entry)
  );

  // destroyed covers peer state three as well
  assign gone      = item_r.peer_state[1];
  assign can_store = found_r || free_r;
  assign slot      = found_r ? found_idx_r : free_idx_r;
  assign hit       = chk_on_r && !found_r && valid_r[chk_idx_r] &&
                     (rd_entry.peer == item_r.peer_id);
  assign free_here = (state_r == sme_pkg::TS_SCAN) && !free_r && !valid_r[addr_r];

  assign wr_entry.peer       = item_r.peer_id;
  assign wr_entry.master     = {item_r.peer_has_master, item_r.peer_master_id};
  assign wr_entry.mode       = item_r.peer_state;
  assign wr_entry.start_time = {item_r.peer_init_sec, item_r.peer_init_nsec};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sme_pkg::TS_IDLE:  if (req) state_nxt = sme_pkg::TS_SCAN;
      sme_pkg::TS_SCAN:  if (addr_r == LAST_IDX) state_nxt = sme_pkg::TS_DRAIN;
      sme_pkg::TS_DRAIN: state_nxt = sme_pkg::TS_WRITE;
      sme_pkg::TS_WRITE: state_nxt = sme_pkg::TS_IDLE;
      default:           state_nxt = sme_pkg::TS_IDLE;
    endcase
  end

  always_comb begin
    writing = (state_r == sme_pkg::TS_WRITE);
    ram_we  = writing && !gone && can_store;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sme_pkg::TS_IDLE;
      addr_r   <= '0;
      chk_on_r <= 1'b0;
      found_r  <= 1'b0;
      free_r   <= 1'b0;
      full_r   <= 1'b0;
      valid_r  <= '0;
      count_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      chk_on_r <= (state_r == sme_pkg::TS_SCAN);
      if (state_r == sme_pkg::TS_IDLE && req) begin
        addr_r  <= '0;
        found_r <= 1'b0;
        free_r  <= 1'b0;
        full_r  <= 1'b0;
      end
      if (state_r == sme_pkg::TS_SCAN && addr_r != LAST_IDX) begin
        addr_r <= addr_r + 1'b1;
      end
      if (free_here) begin
        free_r <= 1'b1;
      end
      if (hit) begin
        found_r <= 1'b1;
      end
      if (writing) begin
        if (gone) begin
          if (found_r) begin
            valid_r[found_idx_r] <= 1'b0;
            count_r              <= count_r - 1'b1;
          end
        end else if (can_store) begin
          valid_r[slot] <= 1'b1;
          if (!found_r) begin
            count_r <= count_r + 1'b1;
          end
        end else begin
          full_r <= 1'b1;
        end
      end
    end
  end

  // payload and index registers
  always_ff @(posedge clk) begin
    if (state_r == sme_pkg::TS_IDLE && req) begin
      item_r <= item;
    end
    chk_idx_r <= addr_r;
    if (free_here) begin
      free_idx_r <= addr_r;
    end
    if (hit) begin
      found_idx_r <= chk_idx_r;
    end
  end

  assign stat.done = writing;
  assign stat.full = full_r;
  assign count     = count_r;

endmodule

// ===== sv/seniority_master_election_top.sv =====
// top level of the seniority master election block: config registers, sequencer
// depends on sme_pkg, sme_elect, sme_table (and sme_ram below it)
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------
//  input    | start, busy               | in_item  (sme_pkg::in_item_t)
//  result   | out_valid (strobe)        | out_item (sme_pkg::out_item_t)
//  config   | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// a heartbeat tick, or any item while detached, gives its result in the cycle after it is
// accepted; busy is high for that cycle only
// a peer announcement walks the neighbour table ram one row per cycle: a read of every
// row, a drain state for the last read, a write state, then a result state; busy stays
// high throughout the walk
// reset clears the valid bits of all rows at once, so no clearing pass is needed
// the result strobe lasts one cycle; config writes are taken only while idle
// and no input is offered
module seniority_master_election_top #(
  parameter int MAX_NODES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  sme_pkg::in_item_t                  in_item,
  output logic                               out_valid,
  output sme_pkg::out_item_t                 out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sme_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sme_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW = $clog2(MAX_NODES + 1);

  sme_pkg::top_state_t state_r, state_nxt;

  logic [sme_pkg::ID_W-1:0]   self_id_r;
  logic [sme_pkg::SEC_W-1:0]  init_sec_r;
  logic [sme_pkg::NSEC_W-1:0] init_nsec_r;
  logic [sme_pkg::LIM_W-1:0]  pend_limit_r;
  logic [sme_pkg::LIM_W-1:0]  sync_limit_r;
  logic                       attached_r;
  logic                       tbl_path_r;

  logic                  accept, cfg_we, tbl_req;
  sme_pkg::elect_cfg_t   e_cfg;
  sme_pkg::elect_cmd_t   e_cmd;
  sme_pkg::elect_stat_t  e_stat;
  sme_pkg::tbl_stat_t    t_stat;
  logic [CW-1:0]         nb_count;

  assign accept  = start && !busy;
  assign cfg_we  = cfg_valid && cfg_ready;
  assign tbl_req = accept && attached_r && (in_item.action == sme_pkg::ACT_ANNOUNCE);

  assign e_cfg.self_id    = self_id_r;
  assign e_cfg.init_sec   = init_sec_r;
  assign e_cfg.init_nsec  = init_nsec_r;
  assign e_cfg.pend_limit = pend_limit_r;
  assign e_cfg.sync_limit = sync_limit_r;

  assign e_cmd.apply    = accept;
  assign e_cmd.attached = attached_r;
  // detaching makes the node its own master at once
  assign e_cmd.detach   = cfg_we && (cfg_index == sme_pkg::CFG_NET_ATTACHED) && !cfg_data[0];

  sme_elect #(
    .MAX_NODES (MAX_NODES)
  ) u_elect (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (e_cfg),
    .cmd      (e_cmd),
    .item     (in_item),
    .nb_count (nb_count),
    .stat     (e_stat)
  );

  sme_table #(
    .MAX_NODES (MAX_NODES)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .item  (in_item),
    .stat  (t_stat),
    .count (nb_count)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sme_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = tbl_req ? sme_pkg::ST_TABLE : sme_pkg::ST_RESULT;
        end
      end
      sme_pkg::ST_TABLE:  if (t_stat.done) state_nxt = sme_pkg::ST_RESULT;
      sme_pkg::ST_RESULT: state_nxt = sme_pkg::ST_IDLE;
      default:            state_nxt = sme_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_r != sme_pkg::ST_IDLE);
    out_valid = (state_r == sme_pkg::ST_RESULT);
    // an offered input goes first, so a write never lands on the same edge
    cfg_ready = (state_r == sme_pkg::ST_IDLE) && !start;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sme_pkg::ST_IDLE;
      self_id_r    <= '0;
      init_sec_r   <= '0;
      init_nsec_r  <= '0;
      pend_limit_r <= sme_pkg::LIM_W'(5);
      sync_limit_r <= sme_pkg::LIM_W'(5);
      attached_r   <= 1'b1;
      tbl_path_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        tbl_path_r <= tbl_req;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          sme_pkg::CFG_SELF_ID:        self_id_r    <= cfg_data[sme_pkg::ID_W-1:0];
          sme_pkg::CFG_SELF_INIT_SEC:  init_sec_r   <= cfg_data[sme_pkg::SEC_W-1:0];
          sme_pkg::CFG_SELF_INIT_NSEC: init_nsec_r  <= cfg_data[sme_pkg::NSEC_W-1:0];
          sme_pkg::CFG_PENDING_LIMIT:  pend_limit_r <= cfg_data[sme_pkg::LIM_W-1:0];
          sme_pkg::CFG_SYNC_LIMIT:     sync_limit_r <= cfg_data[sme_pkg::LIM_W-1:0];
          sme_pkg::CFG_NET_ATTACHED:   attached_r   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    out_item.self_state      = e_stat.mode;
    out_item.master_id       = e_stat.known ? e_stat.master : '0;
    out_item.has_master      = e_stat.known;
    out_item.is_master       = e_stat.known && (e_stat.master == self_id_r);
    out_item.neighbour_count = sme_pkg::CNT_W'(nb_count);
    out_item.announce        = e_stat.announce;
    out_item.replay_request  = e_stat.replay;
    out_item.table_full      = tbl_path_r && t_stat.full;
  end

endmodule

// ===== sv/sme_chk.sv =====
// port-level checker for the seniority master election top, bound to it below
// depends on sme_pkg and seniority_master_election_top
module sme_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input sme_pkg::out_item_t             out_item,
  input logic                           cfg_ready
);

  // a transfer on the input side always leaves the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("no busy after input transfer");

  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy && !cfg_ready)
    else $error("result shown while idle");

  // ready exactly when a master is known
  a_ready_master: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.self_state == out_item.has_master))
    else $error("state and master flag disagree");

  a_no_master: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.has_master) |->
      (out_item.master_id == '0) && !out_item.is_master)
    else $error("master fields set without a master");

endmodule

bind seniority_master_election_top sme_chk u_sme_chk (.*);
